// ===== hdl/dzhp_pkg.sv =====
`timescale 1ns / 1ps

package dzhp_pkg;

    // Parse phases, one per header field or sub-step
    typedef enum logic [3:0] {
        PH_MAGIC1   = 4'd0,
        PH_MAGIC2   = 4'd1,
        PH_METHOD   = 4'd2,
        PH_FLAGS    = 4'd3,
        PH_MTIME    = 4'd4,
        PH_XFLOS    = 4'd5,
        PH_XLEN     = 4'd6,
        PH_SUBHDR   = 4'd7,
        PH_RAFIX    = 4'd8,
        PH_RASIZE   = 4'd9,
        PH_SKIP     = 4'd10,
        PH_FNAME    = 4'd11,
        PH_FCOMMENT = 4'd12,
        PH_FHCRC    = 4'd13,
        PH_DATA     = 4'd14,
        PH_IDLE     = 4'd15
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_OFFSET = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_METHOD    = 3'd1;
    localparam logic [2:0] ERR_NO_EXTRA  = 3'd2;
    localparam logic [2:0] ERR_VERSION   = 3'd3;
    localparam logic [2:0] ERR_LENGTH    = 3'd4;
    localparam logic [2:0] ERR_OVERRUN   = 3'd5;
    localparam logic [2:0] ERR_NO_RA     = 3'd6;
    localparam logic [2:0] ERR_TRUNCATED = 3'd7;

    // Fixed header bytes
    localparam logic [7:0]  GZ_MAGIC1      = 8'h1f;
    localparam logic [7:0]  GZ_MAGIC2      = 8'h8b;
    localparam logic [7:0]  GZ_DEFLATE     = 8'h08;
    localparam logic [15:0] RA_SUBFIELD_ID = 16'h5241;
    localparam logic [15:0] RA_VERSION     = 16'd1;

    // Bit positions in the gzip FLG byte
    localparam int FLG_FHCRC    = 1;
    localparam int FLG_FEXTRA   = 2;
    localparam int FLG_FNAME    = 3;
    localparam int FLG_FCOMMENT = 4;

    // Kept flag bits: [0] FHCRC, [1] FNAME, [2] FCOMMENT
    typedef logic [2:0] opt_flags_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [31:0] mod_time;
        logic [15:0] chunk_total;
        logic [15:0] chunk_length;
        logic [31:0] value;
        logic [15:0] chunk_index;
    } result_t;

    // Next optional field after the given stage
    // (0 after extra, 1 after name, 2 after comment, 3 after header CRC)
    function automatic phase_t next_optional(input logic [1:0] stage, input opt_flags_t flags);
        phase_t ph;
        if (stage == 2'd0 && flags[1])
            ph = PH_FNAME;
        else if (stage <= 2'd1 && flags[2])
            ph = PH_FCOMMENT;
        else if (stage <= 2'd2 && flags[0])
            ph = PH_FHCRC;
        else
            ph = PH_DATA;
        return ph;
    endfunction

endpackage

// ===== hdl/dictzip_header_parser_top.sv =====
`timescale 1ns / 1ps

// Channel   | Dir | tdata                                   | tuser       | tlast
// ----------+-----+-----------------------------------------+-------------+-------------
// s_axis    | in  | data_byte (8)                           | start_req   | end_of_input
// m_axis    | out | chunk_index, value, chunk_length,       | kind (2)    | -
//           |     | chunk_total, mod_time, error_code (120) |             |
//
// One input transfer per cycle while tready is high. The byte is parsed combinationally
// while it is offered; at the accepting edge its result (if any) is loaded into the
// output register, or into a one-entry skid stage if the output is held. So input
// stays open while one result waits; tready drops only when both are full.
// rst_n is asynchronous: the parser returns to the first magic byte, outputs empty.

module dictzip_header_parser_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] start_req
    input  logic         s_axis_tlast,   // end_of_input
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,   // [15:0] chunk_index, [47:16] value,
                                         // [63:48] chunk_length, [79:64] chunk_total,
                                         // [111:80] mod_time, [114:112] error_code
    output logic [1:0]   m_axis_tuser    // [1:0] kind
);
    import dzhp_pkg::*;

    // Parser state
    phase_t      phase_reg,    phase_next;
    logic [2:0]  fbc_reg,      fbc_next;
    opt_flags_t  flags_reg,    flags_next;
    logic [15:0] extra_reg,    extra_next;
    logic [15:0] sub_id_reg,   sub_id_next;
    logic [15:0] sub_len_reg,  sub_len_next;
    logic [31:0] asm_reg,      asm_next;
    logic [15:0] clen_reg,     clen_next;
    logic [15:0] ccount_reg,   ccount_next;
    logic [15:0] cctr_reg,     cctr_next;
    logic [31:0] roff_reg,     roff_next;
    logic [31:0] pos_reg,      pos_next;
    logic [31:0] mtime_reg,    mtime_next;
    logic        found_reg,    found_next;

    // Output register and skid stage
    logic        out_valid_reg,  out_valid_next;
    result_t     out_data_reg,   out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_data_reg,  skid_data_next;

    logic        in_xfer;
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [2:0]  res_code;
    logic [15:0] res_idx;
    logic [31:0] res_val;
    result_t     res;

    assign s_axis_tready = !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Parse one byte
    always_comb
    begin
        logic do_end;
        logic hold_pos;
        logic [7:0] b;

        phase_next   = phase_reg;
        fbc_next     = fbc_reg;
        flags_next   = flags_reg;
        extra_next   = extra_reg;
        sub_id_next  = sub_id_reg;
        sub_len_next = sub_len_reg;
        asm_next     = asm_reg;
        clen_next    = clen_reg;
        ccount_next  = ccount_reg;
        cctr_next    = cctr_reg;
        roff_next    = roff_reg;
        pos_next     = pos_reg;
        mtime_next   = mtime_reg;
        found_next   = found_reg;
        res_valid    = 1'b0;
        res_kind     = KIND_OFFSET;
        res_code     = ERR_MAGIC;
        res_idx      = 16'd0;
        res_val      = 32'd0;
        do_end       = 1'b0;
        hold_pos     = 1'b0;
        b            = s_axis_tdata;

        // start of a new file clears everything
        if (s_axis_tuser)
        begin
            phase_next   = PH_MAGIC1;
            fbc_next     = 3'd0;
            flags_next   = '0;
            extra_next   = 16'd0;
            sub_id_next  = 16'd0;
            sub_len_next = 16'd0;
            asm_next     = 32'd0;
            clen_next    = 16'd0;
            ccount_next  = 16'd0;
            cctr_next    = 16'd0;
            roff_next    = 32'd0;
            pos_next     = 32'd0;
            mtime_next   = 32'd0;
            found_next   = 1'b0;
        end

        if (s_axis_tlast)
        begin
            // end of input: finish or flag truncation
            if (phase_next == PH_DATA)
            begin
                res_valid  = 1'b1;
                res_kind   = KIND_DONE;
                res_val    = pos_next;
                phase_next = PH_IDLE;
            end
            else if (phase_next != PH_IDLE)
            begin
                res_valid  = 1'b1;
                res_kind   = KIND_ERROR;
                res_code   = ERR_TRUNCATED;
                res_val    = pos_next;
                phase_next = PH_IDLE;
            end
        end
        else if (phase_next != PH_IDLE)
        begin
            asm_next = {b, asm_next[31:8]};
            unique case (phase_next)
                PH_MAGIC1:
                begin
                    if (b != GZ_MAGIC1)
                    begin
                        res_valid = 1'b1; res_kind = KIND_ERROR; res_code = ERR_MAGIC;
                        res_val = pos_next; phase_next = PH_IDLE; hold_pos = 1'b1;
                    end
                    else
                        phase_next = PH_MAGIC2;
                end
                PH_MAGIC2:
                begin
                    if (b != GZ_MAGIC2)
                    begin
                        res_valid = 1'b1; res_kind = KIND_ERROR; res_code = ERR_MAGIC;
                        res_val = pos_next; phase_next = PH_IDLE; hold_pos = 1'b1;
                    end
                    else
                        phase_next = PH_METHOD;
                end
                PH_METHOD:
                begin
                    if (b != GZ_DEFLATE)
                    begin
                        res_valid = 1'b1; res_kind = KIND_ERROR; res_code = ERR_METHOD;
                        res_val = pos_next; phase_next = PH_IDLE; hold_pos = 1'b1;
                    end
                    else
                        phase_next = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    flags_next = {b[FLG_FCOMMENT], b[FLG_FNAME], b[FLG_FHCRC]};
                    if (!b[FLG_FEXTRA])
                    begin
                        res_valid = 1'b1; res_kind = KIND_ERROR; res_code = ERR_NO_EXTRA;
                        res_val = pos_next; phase_next = PH_IDLE; hold_pos = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MTIME;
                        fbc_next   = 3'd0;
                    end
                end
                PH_MTIME:
                begin
                    fbc_next = fbc_next + 3'd1;
                    if (fbc_next == 3'd4)
                    begin
                        mtime_next = asm_next;
                        phase_next = PH_XFLOS;
                        fbc_next   = 3'd0;
                    end
                end
                PH_XFLOS:
                begin
                    fbc_next = fbc_next + 3'd1;
                    if (fbc_next == 3'd2)
                    begin
                        phase_next = PH_XLEN;
                        fbc_next   = 3'd0;
                    end
                end
                PH_XLEN:
                begin
                    fbc_next = fbc_next + 3'd1;
                    if (fbc_next == 3'd2)
                    begin
                        extra_next = asm_next[31:16];
                        do_end     = 1'b1;
                    end
                end
                PH_SUBHDR:
                begin
                    if (fbc_next == 3'd0)
                        sub_id_next = {b, 8'd0};
                    else if (fbc_next == 3'd1)
                        sub_id_next = {sub_id_next[15:8], b};
                    fbc_next = fbc_next + 3'd1;
                    if (fbc_next == 3'd4)
                    begin
                        sub_len_next = asm_next[31:16];
                        if (({1'b0, sub_len_next} + 17'd4) > {1'b0, extra_next})
                        begin
                            res_valid = 1'b1; res_kind = KIND_ERROR; res_code = ERR_OVERRUN;
                            res_val = pos_next; phase_next = PH_IDLE; hold_pos = 1'b1;
                        end
                        else
                        begin
                            extra_next = extra_next - sub_len_next - 16'd4;
                            fbc_next   = 3'd0;
                            if (sub_id_next == RA_SUBFIELD_ID)
                            begin
                                found_next = 1'b1;
                                cctr_next  = 16'd0;
                                roff_next  = 32'd0;
                                phase_next = PH_RAFIX;
                            end
                            else if (sub_len_next == 16'd0)
                                do_end = 1'b1;
                            else
                                phase_next = PH_SKIP;
                        end
                    end
                end
                PH_RAFIX:
                begin
                    fbc_next = fbc_next + 3'd1;
                    if (fbc_next == 3'd2)
                    begin
                        if (asm_next[31:16] != RA_VERSION)
                        begin
                            res_valid = 1'b1; res_kind = KIND_ERROR; res_code = ERR_VERSION;
                            res_val = pos_next; phase_next = PH_IDLE; hold_pos = 1'b1;
                        end
                    end
                    else if (fbc_next == 3'd4)
                        clen_next = asm_next[31:16];
                    else if (fbc_next == 3'd6)
                    begin
                        ccount_next = asm_next[31:16];
                        fbc_next    = 3'd0;
                        if ({2'b00, sub_len_next} != ({1'b0, ccount_next, 1'b0} + 18'd6))
                        begin
                            res_valid = 1'b1; res_kind = KIND_ERROR; res_code = ERR_LENGTH;
                            res_val = pos_next; phase_next = PH_IDLE; hold_pos = 1'b1;
                        end
                        else if (ccount_next == 16'd0)
                            do_end = 1'b1;
                        else
                            phase_next = PH_RASIZE;
                    end
                end
                PH_RASIZE:
                begin
                    fbc_next = fbc_next + 3'd1;
                    if (fbc_next == 3'd2)
                    begin
                        fbc_next  = 3'd0;
                        res_valid = 1'b1;
                        res_kind  = KIND_OFFSET;
                        res_idx   = cctr_next;
                        res_val   = roff_next;
                        roff_next = roff_next + {16'd0, asm_next[31:16]};
                        cctr_next = cctr_next + 16'd1;
                        if (cctr_next == ccount_next)
                            do_end = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    sub_len_next = sub_len_next - 16'd1;
                    if (sub_len_next == 16'd0)
                        do_end = 1'b1;
                end
                PH_FNAME:
                begin
                    if (b == 8'd0)
                    begin
                        phase_next = next_optional(2'd1, flags_next);
                        fbc_next   = 3'd0;
                    end
                end
                PH_FCOMMENT:
                begin
                    if (b == 8'd0)
                    begin
                        phase_next = next_optional(2'd2, flags_next);
                        fbc_next   = 3'd0;
                    end
                end
                PH_FHCRC:
                begin
                    fbc_next = fbc_next + 3'd1;
                    if (fbc_next == 3'd2)
                        phase_next = next_optional(2'd3, flags_next);
                end
                PH_DATA:
                begin
                    res_valid  = 1'b1;
                    res_kind   = KIND_DONE;
                    res_val    = pos_next;
                    phase_next = PH_IDLE;
                    hold_pos   = 1'b1;
                end
                PH_IDLE:
                begin
                    hold_pos = 1'b1;
                end
            endcase

            // end of a subfield: next subfield, optional fields or missing RA
            if (do_end)
            begin
                if (extra_next == 16'd0)
                begin
                    if (!found_next)
                    begin
                        res_valid  = 1'b1;
                        res_kind   = KIND_ERROR;
                        res_code   = ERR_NO_RA;
                        res_idx    = 16'd0;
                        res_val    = pos_next;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = next_optional(2'd0, flags_next);
                        fbc_next   = 3'd0;
                    end
                end
                else
                begin
                    phase_next = PH_SUBHDR;
                    fbc_next   = 3'd0;
                end
            end

            if (!hold_pos)
                pos_next = pos_next + 32'd1;
        end
    end

    // Assemble the result item
    always_comb
    begin
        res.kind         = res_kind;
        res.error_code   = res_code;
        res.mod_time     = mtime_next;
        res.chunk_total  = ccount_next;
        res.chunk_length = clen_next;
        res.value        = res_val;
        res.chunk_index  = res_idx;
    end

    // Output register and skid stage steering
    always_comb
    begin
        logic new_res;
        new_res         = in_xfer && res_valid;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = new_res;
                out_data_next  = res;
            end
        end
        else if (new_res)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    // Control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC1;
            fbc_reg        <= 3'd0;
            flags_reg      <= '0;
            extra_reg      <= 16'd0;
            sub_id_reg     <= 16'd0;
            sub_len_reg    <= 16'd0;
            asm_reg        <= 32'd0;
            clen_reg       <= 16'd0;
            ccount_reg     <= 16'd0;
            cctr_reg       <= 16'd0;
            roff_reg       <= 32'd0;
            pos_reg        <= 32'd0;
            mtime_reg      <= 32'd0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                phase_reg   <= phase_next;
                fbc_reg     <= fbc_next;
                flags_reg   <= flags_next;
                extra_reg   <= extra_next;
                sub_id_reg  <= sub_id_next;
                sub_len_reg <= sub_len_next;
                asm_reg     <= asm_next;
                clen_reg    <= clen_next;
                ccount_reg  <= ccount_next;
                cctr_reg    <= cctr_next;
                roff_reg    <= roff_next;
                pos_reg     <= pos_next;
                mtime_reg   <= mtime_next;
                found_reg   <= found_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.kind;
    assign m_axis_tdata  = {5'd0, out_data_reg.error_code, out_data_reg.mod_time,
                            out_data_reg.chunk_total, out_data_reg.chunk_length,
                            out_data_reg.value, out_data_reg.chunk_index};

endmodule
